@@ hw/rtl/bcpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_pkg: shared types and constants of the block cipher padding engine
// Item layouts, padding codes, status codes and the command that the front
// hands to the back through the command queue.
// ----------------------------------------------------------------------------
package bcpe_pkg;

	// Block geometry
	localparam int BLOCK_BYTES = 16;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = $clog2(BLOCK_BYTES);
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_PADDING_TYPE   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_PADDING_ENABLE = 1'b1;

	// Padding types
	localparam logic [1:0] PT_NONE  = 2'd0;
	localparam logic [1:0] PT_PKCS7 = 2'd1;
	localparam logic [1:0] PT_ISO   = 2'd2;
	localparam logic [1:0] PT_ZERO  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_PAD = 2'd1;
	localparam logic [1:0] ST_BAD_LEN = 2'd2;

	localparam logic [7:0] ISO_MARK = 8'h80;

	// Sixteen bytes, byte 0 in bits 7:0
	typedef logic [15:0][7:0] blk_t;

	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_PAD   = 2'd1,
		OP_STRIP = 2'd2
	} op_t;

	typedef struct packed {
		logic        mode;
		logic [63:0] data_low;
		logic [63:0] data_high;
		logic [4:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_low;
		logic [63:0] out_high;
		logic [4:0]  out_count;
		logic        out_last;
		logic [1:0]  status;
	} out_item_t;

	// One command: an optional plain full block, then an optional main result
	typedef struct packed {
		logic             has_pre;
		blk_t             pre_blk;
		logic             has_main;
		blk_t             main_blk;
		logic [CNT_W-1:0] main_cnt;   // count, or fill start for OP_PAD
		logic             main_last;
		logic [1:0]       main_status;
		op_t              main_op;
		logic [1:0]       ptype;
	} cmd_t;

	// Queue handshake between front and queue
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	// Zero the bytes that lie past the block
	function automatic blk_t mask_block(blk_t b);
		blk_t r;
		for (int i = 0; i < 16; i++) begin
			r[i] = (i < BLOCK_BYTES) ? b[i] : 8'h00;
		end
		return r;
	endfunction

	// Take a count above the block size as the block size
	function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] c);
		return (c > CNT_W'(BLOCK_BYTES)) ? CNT_W'(BLOCK_BYTES) : c;
	endfunction

endpackage

@@ hw/rtl/block_cipher_padding_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cipher_padding_engine: PKCS7 / ISO7816 / zero padding of 16-byte blocks
// Pads final blocks before encryption and checks and strips padding after
// decryption, holding one block back in unpad mode.
//
//   channel   direction  handshake                payload
//   in        input      in_valid / in_stall      in_data (in_item_t)
//   out       output     out_valid / out_stall    out_data (out_item_t)
//   config    input      wr_en                    wr_index, wr_data
//
// One item enters per cycle unless the queue is full; an accepted item goes
// into the command queue and from there into the output register.
// A full final block in pad mode (but for zero padding), or a full final unpad
// block behind a held one, yields two results, one after the other.
// The four-entry command queue parts the intake from the result register, so
// input is stalled only when the queue is full.
// Reset clears the held block, the queue and the result register; the padding
// type resets to PKCS7 and padding is enabled.
// ----------------------------------------------------------------------------
module block_cipher_padding_engine (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  bcpe_pkg::in_item_t                       in_data,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output bcpe_pkg::out_item_t                      out_data,
	input  logic                                     wr_en,
	input  logic [bcpe_pkg::REG_IDX_W-1:0]           wr_index,
	input  logic [1:0]                               wr_data
);

	logic [1:0]       ptype_q;
	logic             penable_q;
	bcpe_pkg::q_wr_t  q_wr;
	logic             q_full;
	logic             q_pop;
	logic             head_valid;
	bcpe_pkg::cmd_t   head;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptype_q   <= bcpe_pkg::PT_PKCS7;
			penable_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				bcpe_pkg::REG_PADDING_TYPE:   ptype_q   <= wr_data;
				bcpe_pkg::REG_PADDING_ENABLE: penable_q <= wr_data[0];
				default:                      ptype_q   <= ptype_q;
			endcase
		end
	end

	bcpe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (in_valid),
		.stall   (in_stall),
		.item    (in_data),
		.ptype   (ptype_q),
		.penable (penable_q),
		.q_full  (q_full),
		.q_wr    (q_wr)
	);

	bcpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_wr       (q_wr),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	bcpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.valid      (out_valid),
		.stall      (out_stall),
		.item       (out_data)
	);

endmodule

@@ hw/rtl/bcpe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_front: item intake and classification
// Accepts input items, keeps the held block of unpad mode and turns each item
// into at most one queue command that says which results the back produces.
// ----------------------------------------------------------------------------
module bcpe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  bcpe_pkg::in_item_t  item,
	input  logic [1:0]          ptype,
	input  logic                penable,
	input  logic                q_full,
	output bcpe_pkg::q_wr_t     q_wr
);

	bcpe_pkg::blk_t                 held_blk_q;
	logic                           held_valid_q;
	bcpe_pkg::blk_t                 blk;
	logic [bcpe_pkg::CNT_W-1:0]     cnt;
	logic                           full_blk;
	logic                           pad_off;
	logic                           accept;
	logic                           held_load;
	bcpe_pkg::cmd_t                 cmd;

	assign stall    = q_full;
	assign accept   = valid && !q_full;
	assign blk      = bcpe_pkg::mask_block({item.data_high, item.data_low});
	assign cnt      = bcpe_pkg::clamp_count(item.byte_count);
	assign full_blk = (cnt == bcpe_pkg::CNT_W'(bcpe_pkg::BLOCK_BYTES));
	assign pad_off  = !penable || (ptype == bcpe_pkg::PT_NONE);

	// Classify the item into a command
	always_comb begin
		cmd             = '0;
		cmd.main_op     = bcpe_pkg::OP_PASS;
		cmd.ptype       = ptype;
		cmd.has_main    = 1'b1;
		held_load       = 1'b0;
		if (pad_off) begin
			cmd.main_blk    = blk;
			cmd.main_cnt    = cnt;
			cmd.main_last   = item.last;
			cmd.main_status = (!item.last && !full_blk) ? bcpe_pkg::ST_BAD_LEN
			                                            : bcpe_pkg::ST_OK;
		end else if (!item.mode) begin
			if (!item.last) begin
				cmd.main_blk    = blk;
				cmd.main_cnt    = cnt;
				cmd.main_status = full_blk ? bcpe_pkg::ST_OK : bcpe_pkg::ST_BAD_LEN;
			end else if (full_blk && ptype != bcpe_pkg::PT_ZERO) begin
				// full final block: pass it, then a whole padding block
				cmd.has_pre   = 1'b1;
				cmd.pre_blk   = blk;
				cmd.main_op   = bcpe_pkg::OP_PAD;
				cmd.main_last = 1'b1;
			end else if (ptype == bcpe_pkg::PT_ZERO && cnt == '0) begin
				cmd.main_last = 1'b1;
			end else begin
				cmd.main_blk  = blk;
				cmd.main_cnt  = cnt;
				cmd.main_op   = bcpe_pkg::OP_PAD;
				cmd.main_last = 1'b1;
			end
		end else if (!item.last) begin
			if (!full_blk) begin
				cmd.main_last   = 1'b1;
				cmd.main_status = bcpe_pkg::ST_BAD_LEN;
			end else begin
				// release the held block, hold this one
				cmd.has_pre  = held_valid_q;
				cmd.pre_blk  = held_blk_q;
				cmd.has_main = 1'b0;
				held_load    = 1'b1;
			end
		end else if (cnt == '0 && held_valid_q) begin
			cmd.main_blk  = held_blk_q;
			cmd.main_op   = bcpe_pkg::OP_STRIP;
			cmd.main_last = 1'b1;
		end else if (full_blk) begin
			cmd.has_pre   = held_valid_q;
			cmd.pre_blk   = held_blk_q;
			cmd.main_blk  = blk;
			cmd.main_op   = bcpe_pkg::OP_STRIP;
			cmd.main_last = 1'b1;
		end else begin
			cmd.main_last   = 1'b1;
			cmd.main_status = bcpe_pkg::ST_BAD_LEN;
		end
	end

	assign q_wr.push = accept && (cmd.has_pre || cmd.has_main);
	assign q_wr.cmd  = cmd;

	// Track the held block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= held_load;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_load) begin
			held_blk_q <= blk;
		end
	end

	// A pad-mode item never leaves a block held
	a_pad_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !item.mode |=> !held_valid_q)
		else $error("held block survived a pad-mode item");

	// A released held block always comes out ahead of anything else
	a_held_released: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.mode && !pad_off && held_valid_q && full_blk |-> cmd.has_pre)
		else $error("held block dropped on a full unpad item");

endmodule

@@ hw/rtl/bcpe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_queue: command queue between front and back
// A short register queue that lets the front accept items while the back
// waits on the output side.
// ----------------------------------------------------------------------------
module bcpe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  bcpe_pkg::q_wr_t   q_wr,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output bcpe_pkg::cmd_t    head
);

	localparam int PTR_W = $clog2(bcpe_pkg::QUEUE_DEPTH);

	bcpe_pkg::cmd_t   entries_q [bcpe_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_pop;

	assign full       = (count_q == (PTR_W+1)'(bcpe_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({q_wr.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			entries_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !full)
		else $error("command pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(bcpe_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

@@ hw/rtl/bcpe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_back: command execution and result register
// Carries out the queue head: emits the plain block first, then the main
// result with padding filled in, checked and stripped, or passed as is.
// ----------------------------------------------------------------------------
module bcpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  bcpe_pkg::cmd_t      head,
	output logic                pop,
	output logic                valid,
	input  logic                stall,
	output bcpe_pkg::out_item_t item
);

	localparam int IDX_W = bcpe_pkg::IDX_W;
	localparam int CNT_W = bcpe_pkg::CNT_W;

	logic                   out_valid_q;
	bcpe_pkg::out_item_t    out_q;
	logic                   pre_done_q;
	logic                   emit_pre;
	logic                   load;
	bcpe_pkg::out_item_t    res;
	bcpe_pkg::blk_t         pad_blk;
	bcpe_pkg::blk_t         strip_blk;
	logic [7:0]             pad_val;
	logic [7:0]             pk_val;
	logic                   pk_bad;
	logic                   found;
	logic [IDX_W-1:0]       hi_idx;
	logic                   strip_bad;
	logic [CNT_W-1:0]       strip_len;

	assign emit_pre = head.has_pre && !pre_done_q;
	assign load     = head_valid && (!out_valid_q || !stall);
	assign pop      = load && !(emit_pre && head.has_main);

	// Fill padding from main_cnt up
	assign pad_val = 8'(CNT_W'(bcpe_pkg::BLOCK_BYTES) - head.main_cnt);
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (i >= bcpe_pkg::BLOCK_BYTES || CNT_W'(i) < head.main_cnt) begin
				pad_blk[i] = head.main_blk[i];
			end else if (head.ptype == bcpe_pkg::PT_PKCS7) begin
				pad_blk[i] = pad_val;
			end else if (head.ptype == bcpe_pkg::PT_ISO && CNT_W'(i) == head.main_cnt) begin
				pad_blk[i] = bcpe_pkg::ISO_MARK;
			end else begin
				pad_blk[i] = 8'h00;
			end
		end
	end

	// Check PKCS7 pad bytes
	assign pk_val = head.main_blk[bcpe_pkg::BLOCK_BYTES-1];
	always_comb begin
		pk_bad = (pk_val == 8'h00) || (pk_val > 8'(bcpe_pkg::BLOCK_BYTES));
		for (int j = 0; j < bcpe_pkg::BLOCK_BYTES; j++) begin
			if ((9'(j) + {1'b0, pk_val}) >= 9'(bcpe_pkg::BLOCK_BYTES)
			    && head.main_blk[j] != pk_val) begin
				pk_bad = 1'b1;
			end
		end
	end

	// Find the highest nonzero byte
	always_comb begin
		found  = 1'b0;
		hi_idx = '0;
		for (int i = 0; i < bcpe_pkg::BLOCK_BYTES; i++) begin
			if (head.main_blk[i] != 8'h00) begin
				found  = 1'b1;
				hi_idx = IDX_W'(i);
			end
		end
	end

	// Select stripped length and validity
	always_comb begin
		case (head.ptype)
			bcpe_pkg::PT_PKCS7: begin
				strip_bad = pk_bad;
				strip_len = CNT_W'(bcpe_pkg::BLOCK_BYTES) - pk_val[CNT_W-1:0];
			end
			bcpe_pkg::PT_ISO: begin
				strip_bad = !found || head.main_blk[hi_idx] != bcpe_pkg::ISO_MARK;
				strip_len = CNT_W'(hi_idx);
			end
			default: begin
				strip_bad = 1'b0;
				strip_len = found ? CNT_W'(hi_idx) + 1'b1 : '0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			strip_blk[i] = (CNT_W'(i) < strip_len) ? head.main_blk[i] : 8'h00;
		end
	end

	// Form the result of the current phase
	always_comb begin
		res = '0;
		if (emit_pre) begin
			{res.out_high, res.out_low} = head.pre_blk;
			res.out_count = CNT_W'(bcpe_pkg::BLOCK_BYTES);
			res.status    = bcpe_pkg::ST_OK;
		end else begin
			case (head.main_op)
				bcpe_pkg::OP_PAD: begin
					{res.out_high, res.out_low} = pad_blk;
					res.out_count = CNT_W'(bcpe_pkg::BLOCK_BYTES);
					res.out_last  = head.main_last;
					res.status    = head.main_status;
				end
				bcpe_pkg::OP_STRIP: begin
					res.out_last = 1'b1;
					if (strip_bad) begin
						res.status = bcpe_pkg::ST_BAD_PAD;
					end else begin
						{res.out_high, res.out_low} = strip_blk;
						res.out_count = strip_len;
						res.status    = bcpe_pkg::ST_OK;
					end
				end
				default: begin
					{res.out_high, res.out_low} = head.main_blk;
					res.out_count = head.main_cnt;
					res.out_last  = head.main_last;
					res.status    = head.main_status;
				end
			endcase
		end
	end

	// Hold the result until taken; track the phase of the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pre_done_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pre_done_q  <= !pop;
			end else if (!stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign valid = out_valid_q;
	assign item  = out_q;

	a_phase_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		pre_done_q |-> head_valid && head.has_main)
		else $error("second result pending without its command");

	a_bad_pad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == bcpe_pkg::ST_BAD_PAD |-> out_q.out_count == '0
		&& out_q.out_last)
		else $error("bad padding result carries data");

endmodule

@@ dv/padding_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padding_checker: result predictor and comparator for the padding engine
// Watches the config port and both item channels, works out the result
// blocks each accepted item must produce and compares them in order.
// ----------------------------------------------------------------------------
module padding_checker import bcpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [1:0]           wr_data,
	output int                   mismatches,
	output int                   outstanding
);

	// Mirror of the registers and of the block held back in unpad mode
	logic [1:0] pad_kind;
	logic       pad_on;
	blk_t       held_blk;
	logic       held_full;

	// Result blocks still owed by the engine, oldest first
	out_item_t  owed_blocks[$];

	// Queue one result block
	task automatic owe(blk_t b, logic [4:0] cnt, logic last, logic [1:0] st);
		out_item_t r;
		r.out_low   = b[7:0];
		r.out_high  = b[15:8];
		r.out_count = cnt;
		r.out_last  = last;
		r.status    = st;
		owed_blocks.push_back(r);
	endtask

	// Fill bytes from..15 with the selected padding
	function automatic blk_t fill_tail(blk_t b, int from);
		for (int i = from; i < 16; i++) begin
			if (pad_kind == PT_PKCS7)
				b[i] = 8'(16 - from);
			else if (pad_kind == PT_ISO && i == from)
				b[i] = ISO_MARK;
			else
				b[i] = 8'h00;
		end
		return b;
	endfunction

	// Work out the results of one accepted item and advance the held block
	task automatic run_padding(in_item_t it);
		blk_t       blk;
		blk_t       fin;
		logic [4:0] cnt;
		int         len;
		int         pos;
		int         pad_len;
		cnt = (it.byte_count > 5'd16) ? 5'd16 : it.byte_count;
		blk = {it.data_high, it.data_low};
		if (!pad_on || pad_kind == PT_NONE) begin
			held_full = 1'b0;
			owe(blk, cnt, it.last, (!it.last && cnt < 5'd16) ? ST_BAD_LEN : ST_OK);
		end else if (it.mode == 1'b0) begin
			// pad mode drops anything held from an unpad message
			held_full = 1'b0;
			if (!it.last) begin
				owe(blk, cnt, 1'b0, (cnt < 5'd16) ? ST_BAD_LEN : ST_OK);
			end else if (cnt == 5'd16 && pad_kind != PT_ZERO) begin
				owe(blk, 5'd16, 1'b0, ST_OK);
				owe(fill_tail('0, 0), 5'd16, 1'b1, ST_OK);
			end else if (pad_kind == PT_ZERO && cnt == 5'd0) begin
				owe('0, 5'd0, 1'b1, ST_OK);
			end else begin
				owe(fill_tail(blk, int'(cnt)), 5'd16, 1'b1, ST_OK);
			end
		end else if (!it.last) begin
			if (cnt < 5'd16) begin
				held_full = 1'b0;
				owe('0, 5'd0, 1'b1, ST_BAD_LEN);
			end else begin
				if (held_full)
					owe(held_blk, 5'd16, 1'b0, ST_OK);
				held_blk  = blk;
				held_full = 1'b1;
			end
		end else if ((cnt == 5'd0 && held_full) || cnt == 5'd16) begin
			// final block: release the held one if a new full block arrives
			if (cnt == 5'd16) begin
				if (held_full)
					owe(held_blk, 5'd16, 1'b0, ST_OK);
				fin = blk;
			end else begin
				fin = held_blk;
			end
			held_full = 1'b0;
			if (pad_kind == PT_PKCS7) begin
				pad_len = int'(fin[15]);
				len = 16 - pad_len;
				if (pad_len < 1 || pad_len > 16) begin
					len = -1;
				end else begin
					for (pos = 16 - pad_len; pos < 16; pos++) begin
						if (fin[pos] != fin[15])
							len = -1;
					end
				end
			end else begin
				// skip trailing zeros inside the final block only
				pos = 15;
				while (pos >= 0 && fin[pos] == 8'h00)
					pos--;
				if (pad_kind == PT_ISO)
					len = (pos >= 0 && fin[pos] == ISO_MARK) ? pos : -1;
				else
					len = pos + 1;
			end
			if (len < 0) begin
				owe('0, 5'd0, 1'b1, ST_BAD_PAD);
			end else begin
				for (pos = len; pos < 16; pos++)
					fin[pos] = 8'h00;
				owe(fin, 5'(len), 1'b1, ST_OK);
			end
		end else begin
			held_full = 1'b0;
			owe('0, 5'd0, 1'b1, ST_BAD_LEN);
		end
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Track config, predict on each accepted item, compare each result
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pad_kind    = PT_PKCS7;
			pad_on      = 1'b1;
			held_blk    = '0;
			held_full   = 1'b0;
			mismatches  = 0;
			outstanding = 0;
			owed_blocks.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_PADDING_TYPE:   pad_kind = wr_data;
					REG_PADDING_ENABLE: pad_on   = wr_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				run_padding(in_data);
			if (out_valid && !out_stall) begin
				if (owed_blocks.size() == 0) begin
					$error("result with no block owed: %p", out_data);
					mismatches++;
				end else begin
					want = owed_blocks.pop_front();
					check_field("out_low", want.out_low, out_data.out_low);
					check_field("out_high", want.out_high, out_data.out_high);
					check_field("out_count", 64'(want.out_count), 64'(out_data.out_count));
					check_field("out_last", 64'(want.out_last), 64'(out_data.out_last));
					check_field("status", 64'(want.status), 64'(out_data.status));
				end
			end
			outstanding = owed_blocks.size();
		end
	end

endmodule

@@ dv/block_cipher_padding_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cipher_padding_engine_test: stimulus and verdict for the padding engine
// Runs directed corner items, then well-formed pad and unpad messages mixed
// with corrupted messages and noise under every padding setting, with random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module block_cipher_padding_engine_test;
	import bcpe_pkg::*;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 wr_en     = 1'b0;
	logic [REG_IDX_W-1:0] wr_index  = '0;
	logic [1:0]           wr_data   = '0;

	int                   mismatches;
	int                   outstanding;

	// Idling percentages, item counter and the current register settings
	int                   gap_pct   = 0;
	int                   stall_pct = 0;
	int                   fed       = 0;
	logic [1:0]           cfg_kind  = PT_PKCS7;
	logic                 cfg_on    = 1'b1;
	logic [7:0]           msg_bytes[$];

	logic [1:0]           kinds[5] = '{PT_PKCS7, PT_ISO, PT_ZERO, PT_NONE, PT_PKCS7};
	logic                 ons[5]   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

	block_cipher_padding_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	padding_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the output at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Hard stop in case the engine hangs
	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(logic m, logic [63:0] lo, logic [63:0] hi,
			logic [4:0] cnt, logic last);
		in_item_t it;
		it.mode       = m;
		it.data_low   = lo;
		it.data_high  = hi;
		it.byte_count = cnt;
		it.last       = last;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		fed++;
	endtask

	// Drop valid and wait until every owed result is out, then let the engine settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Write both registers while the engine is idle
	task automatic configure(logic [1:0] kind, logic on);
		drain();
		cfg_kind = kind;
		cfg_on   = on;
		wr_en    <= 1'b1;
		wr_index <= REG_PADDING_TYPE;
		wr_data  <= kind;
		@(posedge clk);
		wr_index <= REG_PADDING_ENABLE;
		wr_data  <= {1'b0, on};
		@(posedge clk);
		wr_en    <= 1'b0;
		@(posedge clk);
	endtask

	// Cut msg_bytes into blocks; bytes past the count are garbage
	task automatic send_bytes(logic m, logic empty_tail);
		int   off;
		int   cnt;
		blk_t b;
		off = 0;
		do begin
			cnt = msg_bytes.size() - off;
			if (cnt > 16)
				cnt = 16;
			for (int i = 0; i < 16; i++)
				b[i] = (i < cnt) ? msg_bytes[off + i] : 8'($urandom);
			send_item(m, b[7:0], b[15:8], 5'(cnt),
				!empty_tail && off + 16 >= msg_bytes.size());
			off += 16;
		end while (off < msg_bytes.size());
		if (empty_tail)
			send_item(m, rnd64(), rnd64(), 5'd0, 1'b1);
	endtask

	// One message: plain pad, well-formed unpad, corrupted unpad, or noise
	task automatic random_message();
		int pick;
		int len;
		int pad;
		int pos;
		pick = $urandom_range(99);
		if (pick >= 88) begin
			send_item(1'($urandom_range(1)), rnd64(), rnd64(), 5'($urandom_range(31)),
				1'($urandom_range(1)));
			return;
		end
		len = $urandom_range(40);
		msg_bytes.delete();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(3) == 0)
				msg_bytes.push_back($urandom_range(1) ? 8'h00 : ISO_MARK);
			else
				msg_bytes.push_back(8'($urandom));
		end
		if (pick < 35) begin
			send_bytes(1'b0, 1'b0);
			return;
		end
		// pad the plaintext the way the current setting expects
		if (cfg_on && cfg_kind != PT_NONE) begin
			pad = 16 - len % 16;
			if (cfg_kind == PT_ZERO && len % 16 == 0)
				pad = (len == 0) ? 16 : 0;
			for (int i = 0; i < pad; i++) begin
				if (cfg_kind == PT_PKCS7)
					msg_bytes.push_back(8'(pad));
				else if (cfg_kind == PT_ISO && i == 0)
					msg_bytes.push_back(ISO_MARK);
				else
					msg_bytes.push_back(8'h00);
			end
		end
		// break some messages: flip a byte near the end or cut the last one
		if (pick >= 75 && msg_bytes.size() > 0) begin
			if ($urandom_range(1)) begin
				pos = msg_bytes.size() - 1 - $urandom_range(15);
				if (pos < 0)
					pos = 0;
				msg_bytes[pos] = msg_bytes[pos] ^ 8'($urandom_range(1, 255));
			end else begin
				void'(msg_bytes.pop_back());
			end
		end
		send_bytes(1'b1, $urandom_range(3) == 0);
	endtask

	initial begin
		int start;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed corners under PKCS7 after reset
		send_item(1'b0, '1, '1, 5'd16, 1'b1);
		send_item(1'b0, '0, '0, 5'd0, 1'b1);
		send_item(1'b0, rnd64(), rnd64(), 5'd15, 1'b1);
		send_item(1'b0, rnd64(), rnd64(), 5'd5, 1'b0);
		send_item(1'b0, rnd64(), rnd64(), 5'd31, 1'b1);
		send_item(1'b1, rnd64(), rnd64(), 5'd16, 1'b0);
		send_item(1'b1, {8{8'h10}}, {8{8'h10}}, 5'd16, 1'b1);
		send_item(1'b1, rnd64(), rnd64(), 5'd0, 1'b1);
		send_item(1'b1, rnd64(), {24'h030303, 40'($urandom)}, 5'd16, 1'b0);
		send_item(1'b1, rnd64(), rnd64(), 5'd0, 1'b1);
		send_item(1'b1, rnd64(), rnd64(), 5'd16, 1'b0);
		send_item(1'b1, rnd64(), rnd64(), 5'd7, 1'b0);
		send_item(1'b1, rnd64(), rnd64(), 5'd16, 1'b0);
		send_item(1'b1, rnd64(), rnd64(), 5'd9, 1'b1);
		send_item(1'b1, rnd64(), {8'h00, 56'(rnd64())}, 5'd16, 1'b1);
		send_item(1'b1, rnd64(), {8'h11, 56'(rnd64())}, 5'd16, 1'b1);
		send_item(1'b1, rnd64(), rnd64(), 5'd16, 1'b0);
		send_item(1'b0, rnd64(), rnd64(), 5'd16, 1'b0);
		send_item(1'b1, rnd64(), {16'h0205, 48'(rnd64())}, 5'd16, 1'b1);
		configure(PT_ISO, 1'b1);
		send_item(1'b1, rnd64(), {8'h80, 56'(rnd64())}, 5'd16, 1'b1);
		send_item(1'b0, rnd64(), rnd64(), 5'd3, 1'b1);
		configure(PT_ZERO, 1'b1);
		send_item(1'b0, rnd64(), rnd64(), 5'd0, 1'b1);
		send_item(1'b1, '0, '0, 5'd16, 1'b1);
		configure(PT_NONE, 1'b1);
		send_item(1'b0, rnd64(), rnd64(), 5'd4, 1'b0);
		configure(PT_PKCS7, 1'b0);
		send_item(1'b1, rnd64(), rnd64(), 5'd16, 1'b1);

		// Random messages: four idling phases, five register settings each
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = (ph == 1) ? 75 : (ph == 3) ? 37 : 0;
			stall_pct = (ph == 2) ? 75 : (ph == 3) ? 37 : 0;
			for (int ck = 0; ck < 5; ck++) begin
				configure(kinds[ck], ons[ck]);
				start = fed;
				while (fed - start < 37)
					random_message();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/bcpe_pkg.sv
hw/rtl/bcpe_front.sv
hw/rtl/bcpe_queue.sv
hw/rtl/bcpe_back.sv
hw/rtl/block_cipher_padding_engine.sv
dv/padding_checker.sv
dv/block_cipher_padding_engine_test.sv
